// ===== rtl/rtnh_pkg.sv =====
package rtnh_pkg;

    localparam int WIDE_W    = 128;
    localparam int DIR_W     = 18;
    localparam int EPS_W     = 16;
    localparam int DIST_W    = 31;
    localparam int DIG_W     = 8;
    localparam int MAC_STEPS = 24;
    localparam int STEP_W    = 5;
    localparam int QUO_MSB   = 30;
    localparam int CNT_W     = 5;

    localparam logic [DIST_W-1:0] DIST_MAX    = '1;
    localparam logic [DIR_W-1:0]  DIR_Z_RESET = 18'h30000;
    localparam logic [EPS_W-1:0]  EPS_RESET   = 16'd1;

    typedef enum logic [2:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_ORIGIN_Z,
        REG_DIR_X,
        REG_DIR_Y,
        REG_DIR_Z,
        REG_EPSILON
    } cfg_reg_t;

    typedef enum logic [3:0] {
        X_E1X, X_E1Y, X_E1Z,
        X_E2X, X_E2Y, X_E2Z,
        X_H0, X_H1, X_H2,
        X_Q0, X_Q1, X_Q2
    } xop_t;

    typedef enum logic [3:0] {
        Y_DX, Y_DY, Y_DZ,
        Y_E1X, Y_E1Y, Y_E1Z,
        Y_E2X, Y_E2Y, Y_E2Z,
        Y_SX, Y_SY, Y_SZ
    } yop_t;

    typedef enum logic [3:0] {
        D_H0, D_H1, D_H2,
        D_Q0, D_Q1, D_Q2,
        D_A, D_UN, D_VN, D_TN
    } dest_t;

    typedef struct packed {
        xop_t  x;
        yop_t  y;
        logic  neg;
        logic  first;
        logic  last;
        dest_t dst;
    } mac_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_NEG,
        ST_CHK0,
        ST_CHK1,
        ST_DIV,
        ST_DONE
    } back_state_t;

    // product sequence: h = d x e2, a = e1.h, un = s.h, q = s x e1, vn = d.q, tn = e2.q
    function automatic mac_op_t mac_op(input logic [STEP_W-1:0] idx);
        mac_op_t r;
        r = '{X_E1X, Y_DX, 1'b0, 1'b0, 1'b0, D_A};
        case (idx)
            5'd0:  r = '{X_E2Z, Y_DY,  1'b0, 1'b1, 1'b0, D_H0};
            5'd1:  r = '{X_E2Y, Y_DZ,  1'b1, 1'b0, 1'b1, D_H0};
            5'd2:  r = '{X_E2X, Y_DZ,  1'b0, 1'b1, 1'b0, D_H1};
            5'd3:  r = '{X_E2Z, Y_DX,  1'b1, 1'b0, 1'b1, D_H1};
            5'd4:  r = '{X_E2Y, Y_DX,  1'b0, 1'b1, 1'b0, D_H2};
            5'd5:  r = '{X_E2X, Y_DY,  1'b1, 1'b0, 1'b1, D_H2};
            5'd6:  r = '{X_H0,  Y_E1X, 1'b0, 1'b1, 1'b0, D_A};
            5'd7:  r = '{X_H1,  Y_E1Y, 1'b0, 1'b0, 1'b0, D_A};
            5'd8:  r = '{X_H2,  Y_E1Z, 1'b0, 1'b0, 1'b1, D_A};
            5'd9:  r = '{X_H0,  Y_SX,  1'b0, 1'b1, 1'b0, D_UN};
            5'd10: r = '{X_H1,  Y_SY,  1'b0, 1'b0, 1'b0, D_UN};
            5'd11: r = '{X_H2,  Y_SZ,  1'b0, 1'b0, 1'b1, D_UN};
            5'd12: r = '{X_E1Z, Y_SY,  1'b0, 1'b1, 1'b0, D_Q0};
            5'd13: r = '{X_E1Y, Y_SZ,  1'b1, 1'b0, 1'b1, D_Q0};
            5'd14: r = '{X_E1X, Y_SZ,  1'b0, 1'b1, 1'b0, D_Q1};
            5'd15: r = '{X_E1Z, Y_SX,  1'b1, 1'b0, 1'b1, D_Q1};
            5'd16: r = '{X_E1Y, Y_SX,  1'b0, 1'b1, 1'b0, D_Q2};
            5'd17: r = '{X_E1X, Y_SY,  1'b1, 1'b0, 1'b1, D_Q2};
            5'd18: r = '{X_Q0,  Y_DX,  1'b0, 1'b1, 1'b0, D_VN};
            5'd19: r = '{X_Q1,  Y_DY,  1'b0, 1'b0, 1'b0, D_VN};
            5'd20: r = '{X_Q2,  Y_DZ,  1'b0, 1'b0, 1'b1, D_VN};
            5'd21: r = '{X_Q0,  Y_E2X, 1'b0, 1'b1, 1'b0, D_TN};
            5'd22: r = '{X_Q1,  Y_E2Y, 1'b0, 1'b0, 1'b0, D_TN};
            5'd23: r = '{X_Q2,  Y_E2Z, 1'b0, 1'b0, 1'b1, D_TN};
            default: r = '{X_E1X, Y_DX, 1'b0, 1'b0, 1'b0, D_A};
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/rtnh_front.sv =====
module rtnh_front #(
    parameter int COORD_WIDTH = 32,
    localparam int EW = COORD_WIDTH + 1,
    localparam int ENT_W = 9 * EW + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] v0_x,
    input  logic signed [COORD_WIDTH-1:0] v0_y,
    input  logic signed [COORD_WIDTH-1:0] v0_z,
    input  logic signed [COORD_WIDTH-1:0] v1_x,
    input  logic signed [COORD_WIDTH-1:0] v1_y,
    input  logic signed [COORD_WIDTH-1:0] v1_z,
    input  logic signed [COORD_WIDTH-1:0] v2_x,
    input  logic signed [COORD_WIDTH-1:0] v2_y,
    input  logic signed [COORD_WIDTH-1:0] v2_z,
    input  logic                          last_triangle,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    output logic                          q_valid,
    input  logic                          q_pop,
    output logic [ENT_W-1:0]              q_data
);

    logic [ENT_W-1:0] mem [0:1];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic [ENT_W-1:0] entry;
    logic             wr_en;

    // edges and origin offset, one bit wider than the coordinates
    always_comb
    begin
        entry = {
            last_triangle,
            EW'(origin_z) - EW'(v0_z),
            EW'(origin_y) - EW'(v0_y),
            EW'(origin_x) - EW'(v0_x),
            EW'(v2_z) - EW'(v0_z),
            EW'(v2_y) - EW'(v0_y),
            EW'(v2_x) - EW'(v0_x),
            EW'(v1_z) - EW'(v0_z),
            EW'(v1_y) - EW'(v0_y),
            EW'(v1_x) - EW'(v0_x)
        };
    end

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign wr_en   = push && !full;
    assign q_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (wr_en && !q_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (q_pop && !wr_en)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/rtnh_back.sv =====
module rtnh_back #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS = 16,
    localparam int EW = COORD_WIDTH + 1,
    localparam int ENT_W = 9 * EW + 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  logic [ENT_W-1:0]                    q_data,
    input  logic signed [rtnh_pkg::DIR_W-1:0]   dir_x,
    input  logic signed [rtnh_pkg::DIR_W-1:0]   dir_y,
    input  logic signed [rtnh_pkg::DIR_W-1:0]   dir_z,
    input  logic [rtnh_pkg::EPS_W-1:0]          epsilon,
    input  logic                                pop,
    output logic                                empty,
    output logic                                any_hit,
    output logic [rtnh_pkg::DIST_W-1:0]         nearest_distance
);

    localparam int WW     = rtnh_pkg::WIDE_W;
    localparam int DGT    = rtnh_pkg::DIG_W;
    localparam int YW     = (EW > rtnh_pkg::DIR_W) ? EW : rtnh_pkg::DIR_W;
    localparam int ND     = (YW + DGT - 1) / DGT;
    localparam int YEXT_W = ND * DGT;
    localparam int DGW    = $clog2(ND);
    localparam int DW     = rtnh_pkg::DIST_W;
    localparam int SH_W   = WW + DW;

    rtnh_pkg::back_state_t state_reg, state_next;

    logic [rtnh_pkg::STEP_W-1:0] step_reg;
    logic [DGW-1:0]              dig_reg;
    logic [rtnh_pkg::CNT_W-1:0]  bit_cnt_reg;
    logic [WW-1:0]               acc_reg;
    logic [WW-1:0]               xsh_reg;
    logic [WW-1:0]               h_reg [0:2];
    logic [WW-1:0]               q_reg [0:2];
    logic [WW-1:0]               a_reg, un_reg, vn_reg, tn_reg;
    logic [WW-1:0]               rem_reg;
    logic [SH_W-1:0]             dsh_reg;
    logic [DW-1:0]               quo_reg;
    logic                        tri_ok_reg;
    logic                        last_reg;
    logic                        out_valid_reg;
    logic                        out_hit_reg;
    logic [DW-1:0]               out_dist_reg;
    logic                        best_hit_reg;
    logic [DW-1:0]               best_dist_reg;

    logic signed [EW-1:0]     fld [0:8];
    rtnh_pkg::mac_op_t        op;
    logic [WW-1:0]            xval;
    logic signed [YEXT_W-1:0] yval;
    logic [DGT-1:0]           digit;
    logic signed [DGT:0]      dig9;
    logic [WW-1:0]            xcur;
    logic [WW-1:0]            prod;
    logic [WW-1:0]            acc_next;
    logic                     dig_last;
    logic                     step_last;
    logic [WW-1:0]            eps_s;
    logic                     miss0, miss1, sat;
    logic [WW-1:0]            uv_sum;
    logic [WW-1:0]            den;
    logic                     ge;
    logic                     t_hit;
    logic                     new_hit;
    logic [DW-1:0]            new_dist;

    logic mac_active;
    logic done_go;
    logic out_load;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            fld[k] = q_data[k*EW +: EW];
        end
    end

    assign op        = rtnh_pkg::mac_op(step_reg);
    assign dig_last  = (dig_reg == DGW'(ND - 1));
    assign step_last = (step_reg == rtnh_pkg::STEP_W'(rtnh_pkg::MAC_STEPS - 1));

    always_comb
    begin
        case (op.x)
            rtnh_pkg::X_E1X: xval = WW'(fld[0]);
            rtnh_pkg::X_E1Y: xval = WW'(fld[1]);
            rtnh_pkg::X_E1Z: xval = WW'(fld[2]);
            rtnh_pkg::X_E2X: xval = WW'(fld[3]);
            rtnh_pkg::X_E2Y: xval = WW'(fld[4]);
            rtnh_pkg::X_E2Z: xval = WW'(fld[5]);
            rtnh_pkg::X_H0:  xval = h_reg[0];
            rtnh_pkg::X_H1:  xval = h_reg[1];
            rtnh_pkg::X_H2:  xval = h_reg[2];
            rtnh_pkg::X_Q0:  xval = q_reg[0];
            rtnh_pkg::X_Q1:  xval = q_reg[1];
            rtnh_pkg::X_Q2:  xval = q_reg[2];
            default:         xval = '0;
        endcase
    end

    always_comb
    begin
        case (op.y)
            rtnh_pkg::Y_DX:  yval = YEXT_W'(dir_x);
            rtnh_pkg::Y_DY:  yval = YEXT_W'(dir_y);
            rtnh_pkg::Y_DZ:  yval = YEXT_W'(dir_z);
            rtnh_pkg::Y_E1X: yval = YEXT_W'(fld[0]);
            rtnh_pkg::Y_E1Y: yval = YEXT_W'(fld[1]);
            rtnh_pkg::Y_E1Z: yval = YEXT_W'(fld[2]);
            rtnh_pkg::Y_E2X: yval = YEXT_W'(fld[3]);
            rtnh_pkg::Y_E2Y: yval = YEXT_W'(fld[4]);
            rtnh_pkg::Y_E2Z: yval = YEXT_W'(fld[5]);
            rtnh_pkg::Y_SX:  yval = YEXT_W'(fld[6]);
            rtnh_pkg::Y_SY:  yval = YEXT_W'(fld[7]);
            rtnh_pkg::Y_SZ:  yval = YEXT_W'(fld[8]);
            default:         yval = '0;
        endcase
    end

    // one digit of y per cycle, the top digit carries the sign
    always_comb
    begin
        digit    = yval[dig_reg*DGT +: DGT];
        dig9     = {dig_last ? digit[DGT-1] : 1'b0, digit};
        xcur     = (dig_reg == '0) ? xval : xsh_reg;
        prod     = WW'($signed(xcur) * dig9);
        acc_next = ((dig_reg == '0 && op.first) ? '0 : acc_reg)
                   + (op.neg ? (WW'(0) - prod) : prod);
    end

    always_comb
    begin
        eps_s  = WW'(epsilon) << (2 * FRAC_BITS);
        uv_sum = un_reg + vn_reg;
        miss0  = (a_reg == '0) || ($signed(a_reg) < $signed(eps_s))
                 || un_reg[WW-1] || ($signed(a_reg) < $signed(un_reg));
        miss1  = vn_reg[WW-1] || ($signed(a_reg) < $signed(uv_sum))
                 || tn_reg[WW-1] || (tn_reg == '0);
        sat    = !(tn_reg < {a_reg[WW-DW-1:0], {DW{1'b0}}});
        den    = dsh_reg[WW-1:0];
        ge     = !(rem_reg < den);
    end

    always_comb
    begin
        t_hit    = tri_ok_reg && (quo_reg > DW'(epsilon));
        new_hit  = best_hit_reg || t_hit;
        new_dist = (t_hit && (quo_reg < best_dist_reg)) ? quo_reg : best_dist_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtnh_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = rtnh_pkg::ST_MAC;
                end
            end
            rtnh_pkg::ST_MAC:
            begin
                if (step_last && dig_last)
                begin
                    state_next = rtnh_pkg::ST_NEG;
                end
            end
            rtnh_pkg::ST_NEG:
            begin
                state_next = rtnh_pkg::ST_CHK0;
            end
            rtnh_pkg::ST_CHK0:
            begin
                state_next = miss0 ? rtnh_pkg::ST_DONE : rtnh_pkg::ST_CHK1;
            end
            rtnh_pkg::ST_CHK1:
            begin
                state_next = (miss1 || sat) ? rtnh_pkg::ST_DONE : rtnh_pkg::ST_DIV;
            end
            rtnh_pkg::ST_DIV:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = rtnh_pkg::ST_DONE;
                end
            end
            rtnh_pkg::ST_DONE:
            begin
                if (done_go)
                begin
                    state_next = rtnh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rtnh_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        mac_active = 1'b0;
        q_pop      = 1'b0;
        done_go    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            rtnh_pkg::ST_MAC:
            begin
                mac_active = 1'b1;
                q_pop      = step_last && dig_last;
            end
            rtnh_pkg::ST_DONE:
            begin
                done_go  = !last_reg || !out_valid_reg || pop;
                out_load = done_go && last_reg;
            end
            default:
            begin
                mac_active = 1'b0;
            end
        endcase
    end

    assign empty            = !out_valid_reg;
    assign any_hit          = out_hit_reg;
    assign nearest_distance = out_dist_reg;

    always_ff @(posedge clk)
    begin
        if (mac_active)
        begin
            acc_reg <= acc_next;
            xsh_reg <= xcur << DGT;
            if (dig_last && op.last)
            begin
                case (op.dst)
                    rtnh_pkg::D_H0: h_reg[0] <= acc_next;
                    rtnh_pkg::D_H1: h_reg[1] <= acc_next;
                    rtnh_pkg::D_H2: h_reg[2] <= acc_next;
                    rtnh_pkg::D_Q0: q_reg[0] <= acc_next;
                    rtnh_pkg::D_Q1: q_reg[1] <= acc_next;
                    rtnh_pkg::D_Q2: q_reg[2] <= acc_next;
                    rtnh_pkg::D_A:  a_reg    <= acc_next;
                    rtnh_pkg::D_UN: un_reg   <= acc_next;
                    rtnh_pkg::D_VN: vn_reg   <= acc_next;
                    rtnh_pkg::D_TN: tn_reg   <= acc_next;
                    default:        ;
                endcase
            end
        end
        if (q_pop)
        begin
            last_reg <= q_data[ENT_W-1];
        end
        case (state_reg)
            rtnh_pkg::ST_NEG:
            begin
                if (a_reg[WW-1])
                begin
                    a_reg  <= WW'(0) - a_reg;
                    un_reg <= WW'(0) - un_reg;
                    vn_reg <= WW'(0) - vn_reg;
                    tn_reg <= WW'(0) - tn_reg;
                end
            end
            rtnh_pkg::ST_CHK0:
            begin
                tri_ok_reg <= !miss0;
            end
            rtnh_pkg::ST_CHK1:
            begin
                tri_ok_reg <= !miss1;
                quo_reg    <= rtnh_pkg::DIST_MAX;
                rem_reg    <= tn_reg;
                dsh_reg    <= {1'b0, a_reg, {(DW - 1){1'b0}}};
            end
            rtnh_pkg::ST_DIV:
            begin
                quo_reg <= {quo_reg[DW-2:0], ge};
                if (ge)
                begin
                    rem_reg <= rem_reg - den;
                end
                dsh_reg <= dsh_reg >> 1;
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
        if (out_load)
        begin
            out_hit_reg  <= new_hit;
            out_dist_reg <= new_dist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtnh_pkg::ST_IDLE;
            step_reg      <= '0;
            dig_reg       <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            best_hit_reg  <= 1'b0;
            best_dist_reg <= rtnh_pkg::DIST_MAX;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rtnh_pkg::ST_IDLE)
            begin
                step_reg <= '0;
                dig_reg  <= '0;
            end
            else if (mac_active)
            begin
                if (dig_last)
                begin
                    dig_reg  <= '0;
                    step_reg <= step_reg + 1'b1;
                end
                else
                begin
                    dig_reg <= dig_reg + 1'b1;
                end
            end
            if (state_reg == rtnh_pkg::ST_CHK1)
            begin
                bit_cnt_reg <= rtnh_pkg::CNT_W'(rtnh_pkg::QUO_MSB);
            end
            else if (state_reg == rtnh_pkg::ST_DIV)
            begin
                bit_cnt_reg <= bit_cnt_reg - 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (done_go)
            begin
                if (last_reg)
                begin
                    best_hit_reg  <= 1'b0;
                    best_dist_reg <= rtnh_pkg::DIST_MAX;
                end
                else
                begin
                    best_hit_reg  <= new_hit;
                    best_dist_reg <= new_dist;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue read while empty");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_dist_reg)
                                     && $stable(out_hit_reg)))
        else $error("waiting result lost or changed");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rtnh_pkg::ST_MAC)
            |-> (step_reg < rtnh_pkg::STEP_W'(rtnh_pkg::MAC_STEPS)))
        else $error("product step out of range");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rtnh_pkg::ST_DIV)
            |-> (bit_cnt_reg <= rtnh_pkg::CNT_W'(rtnh_pkg::QUO_MSB)))
        else $error("quotient bit count out of range");
`endif

endmodule

// ===== rtl/ray_triangle_nearest_hit.sv =====
// nearest ray/triangle hit over a mesh, Moller-Trumbore test in exact fixed point
// configuration: APB-style port, origin, direction and epsilon at byte address
//   4*i (8*i when COORD_WIDTH exceeds 32); write only while no triangle is in flight
// input: one triangle per transfer on push/full; a transfer happens when push is high
//   and full is low; a two-entry queue after the edge subtraction takes triangles
//   while the previous one is still being tested
// output: one result per mesh, after the test of the triangle marked last;
//   any_hit/nearest_distance are valid while empty is low, taken when pop is high
// per triangle: the shared 128x9 multiply-accumulate unit forms 24 products, one digit
//   per cycle, then the 31-step restoring divider finds t unless the triangle misses or
//   saturates before the division
// stall: a result waits in the output register; the engine holds before producing
//   the next result until it is taken, and the queue fills, then full rises
// reset: clears the queue, the nearest-hit state and the registers to origin 0,
//   direction (0,0,-1) and epsilon of one lsb
module ray_triangle_nearest_hit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS = 16,
    localparam int PDW = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int ASH = (PDW == 64) ? 3 : 2,
    localparam int PAW = ASH + 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [PAW-1:0]                      paddr,
    input  logic [PDW-1:0]                      pwdata,
    output logic [PDW-1:0]                      prdata,
    output logic                                pready,
    input  logic                                push,
    output logic                                full,
    input  logic signed [COORD_WIDTH-1:0]       v0_x,
    input  logic signed [COORD_WIDTH-1:0]       v0_y,
    input  logic signed [COORD_WIDTH-1:0]       v0_z,
    input  logic signed [COORD_WIDTH-1:0]       v1_x,
    input  logic signed [COORD_WIDTH-1:0]       v1_y,
    input  logic signed [COORD_WIDTH-1:0]       v1_z,
    input  logic signed [COORD_WIDTH-1:0]       v2_x,
    input  logic signed [COORD_WIDTH-1:0]       v2_y,
    input  logic signed [COORD_WIDTH-1:0]       v2_z,
    input  logic                                last_triangle,
    output logic                                empty,
    input  logic                                pop,
    output logic                                any_hit,
    output logic [rtnh_pkg::DIST_W-1:0]         nearest_distance
);

    localparam int EW = COORD_WIDTH + 1;
    localparam int ENT_W = 9 * EW + 1;

    logic signed [COORD_WIDTH-1:0]       origin_x_reg, origin_y_reg, origin_z_reg;
    logic signed [rtnh_pkg::DIR_W-1:0]   dir_x_reg, dir_y_reg, dir_z_reg;
    logic [rtnh_pkg::EPS_W-1:0]          eps_reg;
    rtnh_pkg::cfg_reg_t                  reg_idx;
    logic                                cfg_wr;

    logic             q_valid;
    logic             q_pop;
    logic [ENT_W-1:0] q_data;

    assign pready  = 1'b1;
    assign reg_idx = rtnh_pkg::cfg_reg_t'(paddr[PAW-1:ASH]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_idx)
            rtnh_pkg::REG_ORIGIN_X: prdata = PDW'(origin_x_reg);
            rtnh_pkg::REG_ORIGIN_Y: prdata = PDW'(origin_y_reg);
            rtnh_pkg::REG_ORIGIN_Z: prdata = PDW'(origin_z_reg);
            rtnh_pkg::REG_DIR_X:    prdata = PDW'(dir_x_reg);
            rtnh_pkg::REG_DIR_Y:    prdata = PDW'(dir_y_reg);
            rtnh_pkg::REG_DIR_Z:    prdata = PDW'(dir_z_reg);
            rtnh_pkg::REG_EPSILON:  prdata = PDW'(eps_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            dir_x_reg    <= '0;
            dir_y_reg    <= '0;
            dir_z_reg    <= rtnh_pkg::DIR_Z_RESET;
            eps_reg      <= rtnh_pkg::EPS_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                rtnh_pkg::REG_ORIGIN_X: origin_x_reg <= pwdata[COORD_WIDTH-1:0];
                rtnh_pkg::REG_ORIGIN_Y: origin_y_reg <= pwdata[COORD_WIDTH-1:0];
                rtnh_pkg::REG_ORIGIN_Z: origin_z_reg <= pwdata[COORD_WIDTH-1:0];
                rtnh_pkg::REG_DIR_X:    dir_x_reg    <= pwdata[rtnh_pkg::DIR_W-1:0];
                rtnh_pkg::REG_DIR_Y:    dir_y_reg    <= pwdata[rtnh_pkg::DIR_W-1:0];
                rtnh_pkg::REG_DIR_Z:    dir_z_reg    <= pwdata[rtnh_pkg::DIR_W-1:0];
                rtnh_pkg::REG_EPSILON:  eps_reg      <= pwdata[rtnh_pkg::EPS_W-1:0];
                default:                eps_reg      <= eps_reg;
            endcase
        end
    end

    rtnh_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .v0_x          (v0_x),
        .v0_y          (v0_y),
        .v0_z          (v0_z),
        .v1_x          (v1_x),
        .v1_y          (v1_y),
        .v1_z          (v1_z),
        .v2_x          (v2_x),
        .v2_y          (v2_y),
        .v2_z          (v2_z),
        .last_triangle (last_triangle),
        .origin_x      (origin_x_reg),
        .origin_y      (origin_y_reg),
        .origin_z      (origin_z_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_data        (q_data)
    );

    rtnh_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_data           (q_data),
        .dir_x            (dir_x_reg),
        .dir_y            (dir_y_reg),
        .dir_z            (dir_z_reg),
        .epsilon          (eps_reg),
        .pop              (pop),
        .empty            (empty),
        .any_hit          (any_hit),
        .nearest_distance (nearest_distance)
    );

endmodule
